// File: src/rsame_pkg.sv
// shared types and constants for the rsa modular exponentiation decrypt block
// no dependencies; imported by every module of the block
package rsame_pkg;

    localparam int DEF_MOD_WIDTH   = 32;
    localparam int DEF_PLAIN_WIDTH = 16;

    localparam int CT_WIDTH   = 32;
    localparam int PT_WIDTH   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 3;

    // register index, taken from paddr[2]
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    localparam logic [DATA_WIDTH-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [DATA_WIDTH-1:0] MODULUS_RESET  = 32'd3;

    typedef struct packed {
        logic load;      // latch request and config, start base reduction
        logic mul_acc;   // product <= acc * sq
        logic mul_sq;    // product <= sq * sq
        logic red_step;  // one bit of the reduction
        logic wr_acc;    // acc <= reduced value
        logic wr_sq;     // sq <= reduced value
        logic next_bit;  // advance to next exponent bit
        logic emit;      // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic red_last;
        logic exp_bit;
        logic bit_last;
        logic mod_zero;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: src/rsame_cfg.sv
// apb register file: private exponent and modulus
// depends on rsame_pkg
module rsame_cfg
    import rsame_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output logic [DATA_WIDTH-1:0] o_private_exponent,
    output logic [DATA_WIDTH-1:0] o_modulus
);

    logic [DATA_WIDTH-1:0] r_exponent;
    logic [DATA_WIDTH-1:0] r_modulus;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET;
            r_modulus  <= MODULUS_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_MODULUS) begin
                r_modulus <= pwdata;
            end else begin
                r_exponent <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? r_modulus : r_exponent;

    assign o_private_exponent = r_exponent;
    assign o_modulus          = r_modulus;

endmodule

// File: src/rsame_dp.sv
// datapath: multiplier, bit-serial reduction, exponent shifter and output register
// depends on rsame_pkg
module rsame_dp
    import rsame_pkg::*;
#(
    parameter int MOD_WIDTH   = DEF_MOD_WIDTH,
    parameter int PLAIN_WIDTH = DEF_PLAIN_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [CT_WIDTH-1:0]   i_ciphertext,
    input  logic [DATA_WIDTH-1:0] i_exponent,
    input  logic [DATA_WIDTH-1:0] i_modulus,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PT_WIDTH-1:0]   o_plaintext,
    output logic                  o_range_error
);

    localparam int W      = MOD_WIDTH;
    localparam int PW     = 2 * MOD_WIDTH;
    localparam int RCNT_W = $clog2(PW);
    localparam int BIT_W  = $clog2(W);

    logic [W-1:0]      r_m;
    logic [W-1:0]      r_exp;
    logic [W-1:0]      r_acc;
    logic [W-1:0]      r_sq;
    logic [PW-1:0]     r_prod;
    logic [W-1:0]      r_rem;
    logic [RCNT_W-1:0] r_red_cnt;
    logic [BIT_W-1:0]  r_bit;
    logic              r_out_valid;
    logic [PT_WIDTH-1:0] r_plain;
    logic              r_err;

    logic [W:0]        rem_sh;
    logic [W:0]        rem_sub;
    logic [W-1:0]      n_rem;
    logic [63:0]       acc_ext;
    logic              too_big;
    logic [W-1:0]      mul_a;

    // restoring reduction: one dividend bit per cycle, msb first
    assign rem_sh  = {r_rem, r_prod[PW-1]};
    assign rem_sub = rem_sh - {1'b0, r_m};
    assign n_rem   = (rem_sh >= {1'b0, r_m}) ? rem_sub[W-1:0] : rem_sh[W-1:0];

    assign mul_a = i_cmd.mul_acc ? r_acc : r_sq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m       <= i_modulus[W-1:0];
            r_exp     <= i_exponent[W-1:0];
            r_prod    <= {{W{1'b0}}, i_ciphertext[W-1:0]};
            r_rem     <= '0;
            r_red_cnt <= '0;
            r_bit     <= '0;
            r_acc     <= (i_modulus[W-1:0] == W'(1)) ? '0 : W'(1);
        end else begin
            if (i_cmd.mul_acc || i_cmd.mul_sq) begin
                r_prod    <= PW'(mul_a) * PW'(r_sq);
                r_rem     <= '0;
                r_red_cnt <= '0;
            end
            if (i_cmd.red_step) begin
                r_prod    <= {r_prod[PW-2:0], 1'b0};
                r_rem     <= n_rem;
                r_red_cnt <= r_red_cnt + 1'b1;
            end
            if (i_cmd.wr_acc) begin
                r_acc <= n_rem;
            end
            if (i_cmd.wr_sq) begin
                r_sq <= n_rem;
            end
            if (i_cmd.next_bit) begin
                r_exp <= {1'b0, r_exp[W-1:1]};
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    assign acc_ext = 64'(r_acc);
    assign too_big = |(acc_ext >> PLAIN_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if ((r_m == '0) || too_big) begin
                r_plain <= '0;
                r_err   <= 1'b1;
            end else begin
                r_plain <= acc_ext[PT_WIDTH-1:0];
                r_err   <= 1'b0;
            end
        end
    end

    assign o_sts.red_last = (r_red_cnt == RCNT_W'(PW - 1));
    assign o_sts.exp_bit  = r_exp[0];
    assign o_sts.bit_last = (r_bit == BIT_W'(W - 1));
    assign o_sts.mod_zero = (r_m == '0);
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_plaintext   = r_plain;
    assign o_range_error = r_err;

endmodule

// File: src/rsame_ctrl.sv
// controller: sequences base reduction and square-and-multiply over exponent bits
// depends on rsame_pkg
module rsame_ctrl
    import rsame_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MACC  = 3'd3;
    localparam logic [2:0] S_RACC  = 3'd4;
    localparam logic [2:0] S_MSQ   = 3'd5;
    localparam logic [2:0] S_RSQ   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BASE;
                end
            end
            S_BASE: begin
                if (i_sts.mod_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.red_step = 1'b1;
                    if (i_sts.red_last) begin
                        o_cmd.wr_sq = 1'b1;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = i_sts.exp_bit ? S_MACC : S_MSQ;
            end
            S_MACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state       = S_RACC;
            end
            S_RACC: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    o_cmd.wr_acc = 1'b1;
                    n_state      = S_MSQ;
                end
            end
            S_MSQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_RSQ;
            end
            S_RSQ: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    o_cmd.wr_sq = 1'b1;
                    if (i_sts.bit_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.next_bit = 1'b1;
                        n_state        = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/rsa_modexp_decrypt_top.sv
// top level of the rsa modular exponentiation decrypt block
// depends on rsame_pkg, rsame_cfg, rsame_ctrl, rsame_dp
//
// Each ciphertext request is raised to the private exponent modulo the modulus by
// right-to-left square-and-multiply, one request at a time; o_in_stall is high from
// acceptance until the result is loaded into the output register, which can hold a
// finished result while the next request is accepted. Every modular product uses one
// MOD_WIDTH x MOD_WIDTH multiply followed by a bit-serial reduction of the
// 2*MOD_WIDTH-bit product; the base is reduced the same way. A zero modulus skips
// the exponentiation and returns range_error. Results wider than PLAIN_WIDTH bits give
// plaintext 0 with range_error set. Registers: exponent at 0x0 (reset 1), modulus at
// 0x4 (reset 3); write them only while the block is idle.
module rsa_modexp_decrypt_top
    import rsame_pkg::*;
#(
    parameter int MOD_WIDTH   = DEF_MOD_WIDTH,
    parameter int PLAIN_WIDTH = DEF_PLAIN_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CT_WIDTH-1:0]   i_ciphertext,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PT_WIDTH-1:0]   o_plaintext,
    output logic                  o_range_error
);

    logic [DATA_WIDTH-1:0] exponent;
    logic [DATA_WIDTH-1:0] modulus;
    t_dp_cmd               cmd;
    t_dp_sts               sts;

    rsame_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_private_exponent (exponent),
        .o_modulus          (modulus)
    );

    rsame_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rsame_dp #(
        .MOD_WIDTH   (MOD_WIDTH),
        .PLAIN_WIDTH (PLAIN_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_ciphertext  (i_ciphertext),
        .i_exponent    (exponent),
        .i_modulus     (modulus),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_plaintext   (o_plaintext),
        .o_range_error (o_range_error)
    );

    // an accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("block not busy after accepting a request");

    // an error result never carries a plaintext value
    a_err_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_plaintext == '0)
    ) else $error("range error with nonzero plaintext");

    // a result is only produced by a request in flight
    a_emit_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> o_in_stall
    ) else $error("result emitted while idle");

    // the output register is never overwritten while a result is stalled
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !cmd.emit
    ) else $error("stalled result overwritten");

endmodule
